>>> hw/rtl/dhc_pkg.sv
// shared constants and codes of the disparity colorizer
package dhc_pkg;

    // pixel and channel widths
    localparam int DISP_W = 8;
    localparam int CHAN_W = 8;

    // default fraction bits of the saturation and value levels
    localparam int LEVEL_FRAC_BITS_DEF = 8;

    // hue span in degrees and width of one hue sector
    localparam int HUE_SPAN   = 240;
    localparam int SECTOR_DEG = 60;

    // quotient and numerator widths of the hue divider
    localparam int HUE_W = 8;
    localparam int NUM_W = 16;

    // register map of the configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DISP   = 2'd0,
        REG_SATURATION = 2'd1,
        REG_VALUE      = 2'd2,
        REG_MASK_ZERO  = 2'd3
    } cfg_reg_t;

endpackage

>>> hw/rtl/dhc_if.sv
// stream interfaces for disparity pixels and colorized pixels

// disparity pixel channel
interface dhc_disp_if import dhc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DISP_W-1:0] disparity;

    modport source (output valid, output disparity, input ready);
    modport sink   (input valid, input disparity, output ready);
endinterface

// colorized pixel channel
interface dhc_color_if import dhc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

>>> hw/rtl/disparity_hsv_colorizer.sv
// disparity to blue/green/red colorizer through an hsv colormap, eight-stage pipeline
// Takes one disparity word per clock and returns one blue/green/red word per clock while
// pix_out is ready. A word sits in the output register, valid on pix_out, after passing
// through the eight register stages: one prepare stage (clamp, black test, hue numerator)
// loaded at the accepting edge, four stages of the hue divider that retire two quotient bits
// each, one stage for sector, fraction and the p/q/t factors, one stage for the multiply by
// the value level, and the clamp-and-scale output register. Stages hold valid bits and empty
// stages fill while the output stalls, so the input takes a word whenever any stage ahead
// of it has room. Registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no word is in flight; max_disparity of zero gives black, and
// mask_zero_pixels blacks out zero disparities.
module disparity_hsv_colorizer import dhc_pkg::*; #(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [((LEVEL_FRAC_BITS + 1 > DISP_W) ? LEVEL_FRAC_BITS + 1 : DISP_W)-1:0] cfg_data,
    dhc_disp_if.sink                pix_in,
    dhc_color_if.source             pix_out
);

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int FW      = LEVEL_FRAC_BITS + 8;
    localparam int PW      = 2 * LEVEL_FRAC_BITS + 9;
    localparam int NW      = 2 * LEVEL_FRAC_BITS + 6;
    localparam int ONE_I   = 1 << LEVEL_FRAC_BITS;
    localparam int FULL_I  = SECTOR_DEG * ONE_I;
    localparam int NSTG    = 8;
    localparam int DIV_STG = 4;
    localparam longint DEN_L = longint'(SECTOR_DEG) << (2 * LEVEL_FRAC_BITS);
    localparam logic signed [PW-1:0] DEN = PW'(DEN_L);

    typedef enum logic [2:0] {
        SEC_RED_YEL   = 3'd0,
        SEC_YEL_GRN   = 3'd1,
        SEC_GRN_CYAN  = 3'd2,
        SEC_CYAN_BLUE = 3'd3,
        SEC_BLUE      = 3'd4
    } hue_sec_t;

    // configuration registers
    logic [DISP_W-1:0]  max_disp_reg;
    logic [LEVEL_W-1:0] sat_reg;
    logic [LEVEL_W-1:0] val_reg;
    logic               mask_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_disp_reg  <= DISP_W'(255);
            sat_reg       <= LEVEL_W'(ONE_I);
            val_reg       <= LEVEL_W'(ONE_I);
            mask_zero_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAX_DISP:   max_disp_reg  <= cfg_data[DISP_W-1:0];
                REG_SATURATION: sat_reg       <= cfg_data[LEVEL_W-1:0];
                REG_VALUE:      val_reg       <= cfg_data[LEVEL_W-1:0];
                REG_MASK_ZERO:  mask_zero_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // stage valid bits and advance chain
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    assign adv[NSTG-1] = !vld_reg[NSTG-1] || pix_out.ready;
    for (genvar i = 0; i < NSTG - 1; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign pix_in.ready = adv[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = pix_in.valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // black flag travels with each word
    logic blk_reg [0:NSTG-2];

    // divider pipeline registers, entry zero is the prepare stage
    logic [NUM_W-1:0] rem_reg [0:DIV_STG];
    logic [HUE_W-1:0] quo_reg [0:DIV_STG];

    // prepare: clamp, black test and hue numerator (max - d) * 240
    logic [DISP_W-1:0] disp_clamp;
    logic [DISP_W-1:0] disp_diff;
    logic              blk_in;

    always_comb
    begin
        disp_clamp = (pix_in.disparity > max_disp_reg) ? max_disp_reg : pix_in.disparity;
        disp_diff  = max_disp_reg - disp_clamp;
        blk_in     = (max_disp_reg == '0) || (mask_zero_reg && (pix_in.disparity == '0));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rem_reg[0] <= NUM_W'(disp_diff) * NUM_W'(HUE_SPAN);
            quo_reg[0] <= '0;
            blk_reg[0] <= blk_in;
        end
    end

    // hue divider, two restoring steps per stage
    for (genvar k = 0; k < DIV_STG; k++)
    begin : g_div
        logic [NUM_W-1:0] rem_c;
        logic [HUE_W-1:0] quo_c;

        always_comb
        begin
            rem_c = rem_reg[k];
            quo_c = quo_reg[k];
            for (int j = 0; j < 2; j++)
            begin
                if (rem_c >= (NUM_W'(max_disp_reg) << (HUE_W - 1 - 2 * k - j)))
                begin
                    rem_c = rem_c - (NUM_W'(max_disp_reg) << (HUE_W - 1 - 2 * k - j));
                    quo_c[HUE_W - 1 - 2 * k - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k+1])
            begin
                rem_reg[k+1] <= rem_c;
                quo_reg[k+1] <= quo_c;
                blk_reg[k+1] <= blk_reg[k];
            end
        end
    end

    // sector, fraction and channel factors
    hue_sec_t          hue_sec;
    logic [HUE_W-1:0]  hue_base;
    logic [5:0]        hue_rem;
    logic signed [FW-1:0] s_x;
    logic signed [FW-1:0] r_x;
    logic signed [FW-1:0] rc_x;
    logic signed [FW-1:0] f_v;
    logic signed [FW-1:0] f_p;
    logic signed [FW-1:0] f_q;
    logic signed [FW-1:0] f_t;
    logic signed [FW-1:0] fac_b_next;
    logic signed [FW-1:0] fac_g_next;
    logic signed [FW-1:0] fac_r_next;
    logic signed [FW-1:0] fac_b_reg;
    logic signed [FW-1:0] fac_g_reg;
    logic signed [FW-1:0] fac_r_reg;

    always_comb
    begin
        if (quo_reg[DIV_STG] >= HUE_W'(4 * SECTOR_DEG))
        begin
            hue_sec  = SEC_BLUE;
            hue_base = HUE_W'(4 * SECTOR_DEG);
        end
        else if (quo_reg[DIV_STG] >= HUE_W'(3 * SECTOR_DEG))
        begin
            hue_sec  = SEC_CYAN_BLUE;
            hue_base = HUE_W'(3 * SECTOR_DEG);
        end
        else if (quo_reg[DIV_STG] >= HUE_W'(2 * SECTOR_DEG))
        begin
            hue_sec  = SEC_GRN_CYAN;
            hue_base = HUE_W'(2 * SECTOR_DEG);
        end
        else if (quo_reg[DIV_STG] >= HUE_W'(SECTOR_DEG))
        begin
            hue_sec  = SEC_YEL_GRN;
            hue_base = HUE_W'(SECTOR_DEG);
        end
        else
        begin
            hue_sec  = SEC_RED_YEL;
            hue_base = '0;
        end
        hue_rem = 6'(quo_reg[DIV_STG] - hue_base);

        s_x  = $signed(FW'(sat_reg));
        r_x  = $signed(FW'(hue_rem));
        rc_x = FW'(SECTOR_DEG) - r_x;
        f_v  = FW'(FULL_I);
        f_p  = (FW'(ONE_I) - s_x) * FW'(SECTOR_DEG);
        f_q  = f_v - r_x * s_x;
        f_t  = f_v - rc_x * s_x;

        case (hue_sec)
            SEC_RED_YEL:
            begin
                fac_b_next = f_p;
                fac_g_next = f_t;
                fac_r_next = f_v;
            end
            SEC_YEL_GRN:
            begin
                fac_b_next = f_p;
                fac_g_next = f_v;
                fac_r_next = f_q;
            end
            SEC_GRN_CYAN:
            begin
                fac_b_next = f_t;
                fac_g_next = f_v;
                fac_r_next = f_p;
            end
            SEC_CYAN_BLUE:
            begin
                fac_b_next = f_v;
                fac_g_next = f_q;
                fac_r_next = f_p;
            end
            default:
            begin
                fac_b_next = f_v;
                fac_g_next = f_p;
                fac_r_next = f_t;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[DIV_STG+1])
        begin
            fac_b_reg             <= fac_b_next;
            fac_g_reg             <= fac_g_next;
            fac_r_reg             <= fac_r_next;
            blk_reg[DIV_STG+1]    <= blk_reg[DIV_STG];
        end
    end

    // multiply by the value level
    logic signed [PW-1:0] v_x;
    logic signed [PW-1:0] prod_b_reg;
    logic signed [PW-1:0] prod_g_reg;
    logic signed [PW-1:0] prod_r_reg;

    assign v_x = $signed(PW'(val_reg));

    always_ff @(posedge clk)
    begin
        if (adv[DIV_STG+2])
        begin
            prod_b_reg         <= v_x * PW'(fac_b_reg);
            prod_g_reg         <= v_x * PW'(fac_g_reg);
            prod_r_reg         <= v_x * PW'(fac_r_reg);
            blk_reg[DIV_STG+2] <= blk_reg[DIV_STG+1];
        end
    end

    // clamp to [0, den] and scale by 255/den, which is 17 / 2^(2f+2)
    function automatic logic [CHAN_W-1:0] scale_chan(input logic signed [PW-1:0] num);
        logic [NW-1:0] clamped;
        logic [NW+4:0] times17;
        if (num < 0)
        begin
            clamped = '0;
        end
        else if (num > DEN)
        begin
            clamped = NW'(DEN);
        end
        else
        begin
            clamped = NW'(num);
        end
        times17 = {clamped, 4'b0000} + (NW+5)'(clamped);
        return times17[2*LEVEL_FRAC_BITS+9:2*LEVEL_FRAC_BITS+2];
    endfunction

    // output register
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] red_reg;

    always_ff @(posedge clk)
    begin
        if (adv[NSTG-1])
        begin
            blue_reg  <= blk_reg[NSTG-2] ? '0 : scale_chan(prod_b_reg);
            green_reg <= blk_reg[NSTG-2] ? '0 : scale_chan(prod_g_reg);
            red_reg   <= blk_reg[NSTG-2] ? '0 : scale_chan(prod_r_reg);
        end
    end

    assign pix_out.valid = vld_reg[NSTG-1];
    assign pix_out.blue  = blue_reg;
    assign pix_out.green = green_reg;
    assign pix_out.red   = red_reg;

    // hue never exceeds the full span on a colored word
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STG] && !blk_reg[DIV_STG] |-> quo_reg[DIV_STG] <= HUE_W'(HUE_SPAN))
        else $error("hue quotient above span");

    // division leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STG] && !blk_reg[DIV_STG] |-> rem_reg[DIV_STG] < NUM_W'(max_disp_reg))
        else $error("hue divider remainder not reduced");

    // a stalled divider word keeps its quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STG] && !adv[DIV_STG] |=> $stable(quo_reg[DIV_STG]))
        else $error("stalled hue word changed");

    // input backs up only when every stage holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

endmodule
